FILE: rtl/centered_moving_average_assert.svh
// assertion macros for the centered moving average block
// no dependencies; included by the modules that assert
`ifndef CENTERED_MOVING_AVERAGE_ASSERT_SVH
`define CENTERED_MOVING_AVERAGE_ASSERT_SVH

// clocked assertion, disabled while reset is low
`define CMA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/cma_pkg.sv
// types and constants of the centered moving average block
// used by cma_ctrl, cma_dp and centered_moving_average
`default_nettype none
package cma_pkg;

  localparam int RING_DEPTH = 31;
  localparam int VSUM_W     = 37;
  localparam int CSUM_W     = 21;
  localparam int DIV_STEPS  = 37;

  typedef struct packed {
    logic [31:0]        sample_time;
    logic signed [31:0] sample_value;
    logic [15:0]        sample_confidence;
    logic [7:0]         quality_flags;
    logic               is_valid;
    logic               emit_wanted;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        out_time;
    logic signed [31:0] mean_value;
    logic [15:0]        mean_confidence;
    logic [7:0]         merged_flags;
    logic               final_result;
  } out_item_t;

  typedef struct packed {
    logic [31:0] time_v;
    logic [31:0] value;
    logic [15:0] conf;
    logic [7:0]  flags;
    logic        emit;
  } ring_entry_t;

  localparam int ENTRY_W = $bits(ring_entry_t);

  typedef struct packed {
    logic load;
    logic set_center;
    logic rd_age;
    logic start_sum;
    logic add_age;
    logic start_div;
    logic div_step;
    logic store_pend;
    logic push_pend;
    logic push_final;
    logic flush_init;
    logic flush_dec;
    logic end_series;
  } cmd_t;

  typedef struct packed {
    logic item_valid;
    logic item_last;
    logic seen_gt_h;
    logic center_emit;
    logic age_zero;
    logic div_done;
    logic pend_valid;
    logic out_free;
    logic flush_any;
    logic flushing;
    logic ac_zero;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/cma_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module cma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/cma_ctrl.sv
// controller state machine of the centered moving average block
// depends on cma_pkg and centered_moving_average_assert.svh
`default_nettype none
`include "centered_moving_average_assert.svh"
module cma_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire cma_pkg::status_t sts,
  output cma_pkg::cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK_NEW, ST_C_RD, ST_C_CHK, ST_S_RD, ST_S_ADD,
    ST_DIV_INIT, ST_DIV, ST_PEND, ST_NEXT, ST_FLUSH_CHK, ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_CHECK_NEW;
        end
      end
      ST_CHECK_NEW: begin
        if (sts.item_valid && sts.seen_gt_h) begin
          cmd.set_center = 1'b1;
          state_nxt = ST_C_RD;
        end else begin
          state_nxt = ST_FLUSH_CHK;
        end
      end
      ST_C_RD: state_nxt = ST_C_CHK;
      ST_C_CHK: begin
        if (sts.center_emit) begin
          cmd.start_sum = 1'b1;
          state_nxt = ST_S_RD;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_S_RD: begin
        cmd.rd_age = 1'b1;
        state_nxt = ST_S_ADD;
      end
      ST_S_ADD: begin
        cmd.add_age = 1'b1;
        state_nxt = sts.age_zero ? ST_DIV_INIT : ST_S_RD;
      end
      ST_DIV_INIT: begin
        cmd.start_div = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_PEND;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_PEND: begin
        if (!sts.pend_valid || sts.out_free) begin
          cmd.store_pend = 1'b1;
          cmd.push_pend = sts.pend_valid;
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (sts.flushing) begin
          if (sts.ac_zero) begin
            state_nxt = ST_FINISH;
          end else begin
            cmd.flush_dec = 1'b1;
            state_nxt = ST_C_RD;
          end
        end else begin
          state_nxt = ST_FLUSH_CHK;
        end
      end
      ST_FLUSH_CHK: begin
        if (sts.item_last && sts.flush_any) begin
          cmd.flush_init = 1'b1;
          state_nxt = ST_C_RD;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts.pend_valid || sts.out_free) begin
          cmd.push_pend = sts.pend_valid;
          cmd.push_final = sts.item_last;
          cmd.end_series = sts.item_last;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `CMA_ASSERT(a_push_needs_room, clk, rst_n, cmd.push_pend |-> sts.out_free, "push into busy output")
  `CMA_ASSERT(a_push_has_data, clk, rst_n, cmd.push_pend |-> sts.pend_valid, "push without result")
  `CMA_ASSERT(a_load_leaves_idle, clk, rst_n, cmd.load |=> !in_ready, "ready after request")

endmodule
`default_nettype wire

FILE: rtl/cma_dp.sv
// datapath of the centered moving average block: ring, sums, serial divider, output
// depends on cma_pkg, cma_ram and centered_moving_average_assert.svh
`default_nettype none
`include "centered_moving_average_assert.svh"
module cma_dp #(
  parameter int MAX_HALF_WIDTH = 15
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cma_pkg::in_item_t   in_data,
  input  wire logic                cfg_valid,
  input  wire logic [4:0]          cfg_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cma_pkg::out_item_t       out_data,
  input  wire cma_pkg::cmd_t       cmd,
  output cma_pkg::status_t         sts
);

  localparam logic [4:0] MAXH = 5'(MAX_HALF_WIDTH);
  localparam logic [4:0] LAST_SLOT = 5'(cma_pkg::RING_DEPTH - 1);
  localparam logic [5:0] DEPTH6 = 6'(cma_pkg::RING_DEPTH);
  localparam logic [5:0] STEPS = 6'(cma_pkg::DIV_STEPS);

  logic [4:0] ws_r;
  logic [4:0] wp_r;
  logic [5:0] seen_r;
  logic       flushing_r;
  logic [3:0] ac_r;
  logic [4:0] age_r;
  logic [4:0] n_r;
  logic [31:0] time_r;
  logic signed [cma_pkg::VSUM_W-1:0] vsum_r;
  logic [cma_pkg::CSUM_W-1:0] csum_r;
  logic [7:0] flags_r;
  logic       neg_r;
  logic [cma_pkg::VSUM_W-1:0] vdiv_r, cdiv_r;
  logic [4:0] vrem_r, crem_r;
  logic [5:0] cnt_r;
  cma_pkg::in_item_t item_r;
  cma_pkg::out_item_t pend_r, out_r;
  logic pend_valid_r, out_valid_r;

  logic [4:0] hsel;
  logic [3:0] h;
  logic [4:0] rd_sel, newest, raddr;
  logic [5:0] diff;
  logic [5:0] avail;
  logic [3:0] left, fstart;
  logic       we;
  cma_pkg::ring_entry_t wentry, rentry;
  logic [cma_pkg::ENTRY_W-1:0] rdata;
  logic [cma_pkg::VSUM_W-1:0] mag;
  logic [5:0] vtrial, ctrial;
  logic       vbit, cbit;
  logic [31:0] mean_v;
  logic       out_free;

  assign hsel = ({1'b0, ws_r[4:1]} > MAXH) ? MAXH : {1'b0, ws_r[4:1]};
  assign h = hsel[3:0];

  assign newest = (wp_r == 5'd0) ? LAST_SLOT : wp_r - 5'd1;
  assign rd_sel = cmd.rd_age ? age_r : {1'b0, ac_r};
  assign diff = {1'b0, newest} - {1'b0, rd_sel};
  always_comb begin
    logic [5:0] wrapped;
    wrapped = diff + DEPTH6;
    raddr = diff[5] ? wrapped[4:0] : diff[4:0];
  end

  assign we = cmd.load && in_data.is_valid;
  assign wentry = '{time_v: in_data.sample_time, value: in_data.sample_value,
                    conf: in_data.sample_confidence, flags: in_data.quality_flags,
                    emit: in_data.emit_wanted};

  cma_ram #(.WIDTH(cma_pkg::ENTRY_W), .DEPTH(cma_pkg::RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (wp_r),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rdata)
  );
  assign rentry = rdata;

  assign avail = seen_r - 6'd1 - {2'b0, ac_r};
  assign left = (avail > {2'b0, h}) ? h : avail[3:0];
  assign fstart = ((seen_r - 6'd1) < {2'b0, h - 4'd1}) ? 4'(seen_r - 6'd1) : h - 4'd1;

  assign mag = vsum_r[cma_pkg::VSUM_W-1] ? 37'(-vsum_r) : 37'(vsum_r);
  assign vtrial = {vrem_r, vdiv_r[cma_pkg::VSUM_W-1]};
  assign ctrial = {crem_r, cdiv_r[cma_pkg::VSUM_W-1]};
  assign vbit = vtrial >= {1'b0, n_r};
  assign cbit = ctrial >= {1'b0, n_r};
  assign mean_v = neg_r ? -vdiv_r[31:0] : vdiv_r[31:0];

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= 5'd5;
      wp_r <= '0;
      seen_r <= '0;
      flushing_r <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        ws_r <= cfg_data;
      end
      if (cmd.load) begin
        flushing_r <= 1'b0;
        if (in_data.is_valid) begin
          wp_r <= (wp_r == LAST_SLOT) ? 5'd0 : wp_r + 5'd1;
          seen_r <= (seen_r == 6'd63) ? seen_r : seen_r + 6'd1;
        end
      end
      if (cmd.flush_init) begin
        flushing_r <= 1'b1;
      end
      if (cmd.end_series) begin
        wp_r <= '0;
        seen_r <= '0;
      end
      if (cmd.store_pend) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.push_pend) begin
        pend_valid_r <= 1'b0;
      end
      if (cmd.push_pend) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.set_center) begin
      ac_r <= h;
    end
    if (cmd.flush_init) begin
      ac_r <= fstart;
    end
    if (cmd.flush_dec) begin
      ac_r <= ac_r - 4'd1;
    end
    if (cmd.start_sum) begin
      time_r <= rentry.time_v;
      age_r <= {1'b0, ac_r} + {1'b0, left};
      n_r <= {1'b0, left} + {1'b0, ac_r} + 5'd1;
      vsum_r <= '0;
      csum_r <= '0;
      flags_r <= '0;
    end
    if (cmd.add_age) begin
      vsum_r <= vsum_r + 37'(signed'(rentry.value));
      csum_r <= csum_r + 21'(rentry.conf);
      flags_r <= flags_r | rentry.flags;
      if (age_r != 5'd0) begin
        age_r <= age_r - 5'd1;
      end
    end
    if (cmd.start_div) begin
      neg_r <= vsum_r[cma_pkg::VSUM_W-1];
      vdiv_r <= mag;
      cdiv_r <= 37'(csum_r);
      vrem_r <= '0;
      crem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      vrem_r <= vbit ? 5'(vtrial - {1'b0, n_r}) : vtrial[4:0];
      crem_r <= cbit ? 5'(ctrial - {1'b0, n_r}) : ctrial[4:0];
      vdiv_r <= {vdiv_r[cma_pkg::VSUM_W-2:0], vbit};
      cdiv_r <= {cdiv_r[cma_pkg::VSUM_W-2:0], cbit};
      cnt_r <= cnt_r + 6'd1;
    end
    if (cmd.push_pend) begin
      out_r <= {pend_r[$bits(cma_pkg::out_item_t)-1:1], cmd.push_final};
    end
    if (cmd.store_pend) begin
      pend_r <= '{out_time: time_r, mean_value: mean_v,
                  mean_confidence: cdiv_r[15:0], merged_flags: flags_r,
                  final_result: 1'b0};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  assign sts.item_valid = item_r.is_valid;
  assign sts.item_last = item_r.last_point;
  assign sts.seen_gt_h = seen_r > {2'b0, h};
  assign sts.center_emit = rentry.emit;
  assign sts.age_zero = (age_r == 5'd0);
  assign sts.div_done = (cnt_r == STEPS);
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free = out_free;
  assign sts.flush_any = (seen_r != 6'd0) && (h != 4'd0);
  assign sts.flushing = flushing_r;
  assign sts.ac_zero = (ac_r == 4'd0);

  `CMA_ASSERT_ALWAYS(a_wp_range, clk, !rst_n || wp_r <= LAST_SLOT, "ring pointer out of range")
  `CMA_ASSERT(a_end_clears, clk, rst_n, cmd.end_series |=> (seen_r == 6'd0 && wp_r == 5'd0), "series not cleared")
  `CMA_ASSERT(a_push_shows, clk, rst_n, cmd.push_pend |=> out_valid_r, "pushed result not shown")

endmodule
`default_nettype wire

FILE: rtl/centered_moving_average.sv
// top level of the centered moving average block
// depends on cma_pkg, cma_ctrl, cma_dp and cma_ram
//
//  channel  | handshake              | payload
//  in_      | in_valid / in_ready    | in_data   (cma_pkg::in_item_t)
//  out_     | out_valid / out_ready  | out_data  (cma_pkg::out_item_t)
//  cfg_     | cfg_valid / cfg_ready  | cfg_data  (window_size, 5 bits)
//
// one request at a time; a request loads the point, checks it and, when a centre is
// checked, reads that centre from the ring; a flush checks each flushed centre in turn
// each result reads its window points one at a time, then takes 37 divider steps
// and is stored; the serial divider and the ring reads set the pace
// reset clears the ring pointer, point count and handshake state; no clearing pass
// a stalled output holds back any request that has a result to hand over
`default_nettype none
module centered_moving_average #(
  parameter int MAX_HALF_WIDTH = 15
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cma_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cma_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [4:0]         cfg_data
);

  cma_pkg::cmd_t    cmd;
  cma_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  cma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cma_dp #(.MAX_HALF_WIDTH(MAX_HALF_WIDTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire
